>>> rtl/rsp_pkg.sv
// Shared types and constants of the RESP stream parser.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rsp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned BulkW    = 30;
  localparam int unsigned SimpleW  = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AccumW   = 36;

  localparam logic [ByteW-1:0] ChColon  = 8'h3A;
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam logic [CfgIdxW-1:0] RegMaxSimple = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMaxBulk   = 8'd1;

  localparam logic [SimpleW-1:0] MaxSimpleReset = 16'd128;
  localparam logic [BulkW-1:0]   MaxBulkReset   = 30'd536870912;

  localparam logic [AccumW-1:0] IntPosLimit = 36'h07FFFFFFF;
  localparam logic [AccumW-1:0] IntNegLimit = 36'h080000000;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SIGN      = 4'd1,
    PH_NUM       = 4'd2,
    PH_NUM_LF    = 4'd3,
    PH_SIMPLE    = 4'd4,
    PH_SIMPLE_LF = 4'd5,
    PH_BULK      = 4'd6,
    PH_BULK_CR   = 4'd7,
    PH_BULK_LF   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_SIMPLE = 3'd1,
    KIND_ERR    = 3'd2,
    KIND_BULK   = 3'd3,
    KIND_ARRAY  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    EV_ARRAY_HDR = 3'd0,
    EV_START     = 3'd1,
    EV_PAYLOAD   = 3'd2,
    EV_END       = 3'd3,
    EV_ERROR     = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_TYPE   = 3'd1,
    ERR_MISSING_LF = 3'd2,
    ERR_BAD_DIGIT  = 3'd3,
    ERR_OVERFLOW   = 3'd4,
    ERR_TOO_LONG   = 3'd5,
    ERR_BAD_TERM   = 3'd6,
    ERR_NESTED     = 3'd7
  } err_e;

  // Per-element parse state.
  typedef struct packed {
    phase_e             phase;
    kind_e              kind;
    logic [ValueW-1:0]  accum;
    logic               neg;
    logic               digit_seen;
    logic [BulkW-1:0]   remaining;
    logic [SimpleW-1:0] simple_cnt;
  } elem_state_t;

  // One output event.
  typedef struct packed {
    event_e             event_res;
    kind_e              elem_type;
    logic [ByteW-1:0]   data_byte;
    logic [ValueW-1:0]  value;
    logic [IndexW-1:0]  elem_index;
    err_e               error_code;
    logic               msg_last;
  } result_t;

  localparam elem_state_t ElemClear = '{
    phase:      PH_IDLE,
    kind:       KIND_INT,
    accum:      '0,
    neg:        1'b0,
    digit_seen: 1'b0,
    remaining:  '0,
    simple_cnt: '0
  };

  localparam result_t ResNone = '{
    event_res:  EV_ARRAY_HDR,
    elem_type:  KIND_INT,
    data_byte:  '0,
    value:      '0,
    elem_index: '0,
    error_code: ERR_NONE,
    msg_last:   1'b0
  };

endpackage

`default_nettype wire

>>> rtl/rsp_byte_if.sv
// Input byte channel of the RESP stream parser.
// Depends on rsp_pkg for the byte width.
`default_nettype none

interface rsp_byte_if
  import rsp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/rsp_event_if.sv
// Event output channel of the RESP stream parser.
// Depends on rsp_pkg for the field widths.
`default_nettype none

interface rsp_event_if
  import rsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [2:0]               event_res;
  logic [2:0]               elem_type;
  logic [ByteW-1:0]         data_byte;
  logic signed [ValueW-1:0] value;
  logic [IndexW-1:0]        elem_index;
  logic [2:0]               error_code;
  logic                     msg_last;

  modport source (
    output valid, output event_res, output elem_type, output data_byte,
    output value, output elem_index, output error_code, output msg_last,
    input ready
  );
  modport sink (
    input valid, input event_res, input elem_type, input data_byte,
    input value, input elem_index, input error_code, input msg_last,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rsp_cfg_if.sv
// Configuration write channel of the RESP stream parser.
// Depends on rsp_pkg for the index and data widths.
`default_nettype none

interface rsp_cfg_if
  import rsp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/resp_stream_parser_unit.sv
// Top level of the RESP stream parser: byte input register, parse state and event register.
// Depends on rsp_pkg, the three channel interfaces, rsp_cfg_regs and rsp_step.
//
// Use: bytes of a RESP2 stream enter on byte_i, one word per handshake. Each
// byte yields at most one event word on evt_o: an array header, an element
// start, a payload byte, an element end (carrying the integer value or the
// string length) or an error. A message is a single element or one top-level
// array with its elements; msg_last marks the event that completes it. Any
// error drops the parser back to idle outside any array.
// An accepted byte waits in the input register until the parse step loads
// its event word into the event register. Throughput is one byte per cycle
// while evt_o does not stall; the parse step is one short state update.
// When evt_o stalls, the event register holds its word and the input register
// holds the next byte, so byte_i keeps taking words until both are full.
// Bytes that produce no event also wait behind a stalled event word.
// At reset both registers empty, the parse state returns to idle and the
// length limits take their defaults. The limits are written on cfg_i, whose
// ready is always high; they should only change while the parser is idle.
`default_nettype none

module resp_stream_parser_unit
  import rsp_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rsp_byte_if.sink    byte_i,
  rsp_event_if.source evt_o,
  rsp_cfg_if.sink     cfg_i
);

  localparam int unsigned LeftW = $clog2(MAX_ELEMENTS + 1);

  // Configured limits.
  logic [SimpleW-1:0] max_simple;
  logic [BulkW-1:0]   max_bulk;

  rsp_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .max_simple_o (max_simple),
    .max_bulk_o   (max_bulk)
  );

  // Input register.
  logic             byte_vld_q;
  logic [ByteW-1:0] byte_q;

  // Parse state: the element being parsed and the enclosing array.
  elem_state_t       elem_q, elem_d;
  logic [LeftW-1:0]  left_q, left_d;
  logic [IndexW-1:0] pos_q, pos_d;
  logic              inside_q, inside_d;

  // Event register.
  logic    out_vld_q;
  result_t res_q;
  logic    res_vld;
  result_t res;

  logic advance;
  logic in_fire;

  // The parse step runs whenever a byte is held and the event register can
  // take a word, whether or not this byte produces one.
  assign advance      = byte_vld_q && (!out_vld_q || evt_o.ready);
  assign byte_i.ready = !byte_vld_q || advance;
  assign in_fire      = byte_i.valid && byte_i.ready;

  rsp_step #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LeftW        (LeftW)
  ) u_step (
    .byte_i       (byte_q),
    .max_simple_i (max_simple),
    .max_bulk_i   (max_bulk),
    .elem_i       (elem_q),
    .left_i       (left_q),
    .pos_i        (pos_q),
    .inside_i     (inside_q),
    .elem_o       (elem_d),
    .left_o       (left_d),
    .pos_o        (pos_d),
    .inside_o     (inside_d),
    .res_valid_o  (res_vld),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      byte_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= byte_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q   <= ElemClear;
      left_q   <= '0;
      pos_q    <= '0;
      inside_q <= 1'b0;
    end else if (advance) begin
      elem_q   <= elem_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (evt_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      res_q <= res;
    end
  end

  assign evt_o.valid      = out_vld_q;
  assign evt_o.event_res  = res_q.event_res;
  assign evt_o.elem_type  = res_q.elem_type;
  assign evt_o.data_byte  = res_q.data_byte;
  assign evt_o.value      = $signed(res_q.value);
  assign evt_o.elem_index = res_q.elem_index;
  assign evt_o.error_code = res_q.error_code;
  assign evt_o.msg_last   = res_q.msg_last;

  // Outside an array the element position is always back at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inside_q |-> (pos_q == '0))
    else $error("element position left non-zero outside an array");

  // A stalled event word freezes the parse state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !evt_o.ready) |=> ($stable(elem_q) && $stable(inside_q)))
    else $error("parse state moved while the event word was stalled");

  // A word that completes a message never carries an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.msg_last) |-> (res_q.error_code == ERR_NONE))
    else $error("message completion flagged on an error event");

  // An accepted byte is held in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> byte_vld_q)
    else $error("accepted byte was lost from the input register");

endmodule

`default_nettype wire

>>> rtl/rsp_cfg_regs.sv
// Length limit registers of the RESP stream parser, written over the config channel.
// Depends on rsp_pkg and rsp_cfg_if.
`default_nettype none

module rsp_cfg_regs
  import rsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  rsp_cfg_if.sink           cfg_i,
  output logic [SimpleW-1:0] max_simple_o,
  output logic [BulkW-1:0]   max_bulk_o
);

  logic [SimpleW-1:0] max_simple_q;
  logic [BulkW-1:0]   max_bulk_q;

  assign cfg_i.ready = 1'b1;

  // Writes to indexes beyond the register list are taken and dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_simple_q <= MaxSimpleReset;
      max_bulk_q   <= MaxBulkReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegMaxSimple) begin
        max_simple_q <= cfg_i.data[SimpleW-1:0];
      end
      if (cfg_i.index == RegMaxBulk) begin
        max_bulk_q <= cfg_i.data[BulkW-1:0];
      end
    end
  end

  assign max_simple_o = max_simple_q;
  assign max_bulk_o   = max_bulk_q;

endmodule

`default_nettype wire

>>> rtl/rsp_step.sv
// Next-state and event logic for one byte of the RESP stream parser.
// Depends on rsp_pkg; purely combinational, the state registers live in the top level.
`default_nettype none

module rsp_step
  import rsp_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LeftW        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic [ByteW-1:0]   byte_i,
  input  logic [SimpleW-1:0] max_simple_i,
  input  logic [BulkW-1:0]   max_bulk_i,
  input  elem_state_t        elem_i,
  input  logic [LeftW-1:0]   left_i,
  input  logic [IndexW-1:0]  pos_i,
  input  logic               inside_i,
  output elem_state_t        elem_o,
  output logic [LeftW-1:0]   left_o,
  output logic [IndexW-1:0]  pos_o,
  output logic               inside_o,
  output logic               res_valid_o,
  output result_t            res_o
);

  localparam logic [AccumW-1:0] ArrayLimit = AccumW'(MAX_ELEMENTS);

  logic [IndexW-1:0] idx;
  logic              is_digit;
  logic [AccumW-1:0] nv;
  logic [AccumW-1:0] limit;
  logic [LeftW-1:0]  left_dec;
  logic [BulkW-1:0]  rem_dec;
  logic              do_num;
  logic              do_fail;
  kind_e             fail_kind;
  err_e              fail_code;
  logic              do_fin;
  logic [ValueW-1:0] fin_val;

  assign idx      = inside_i ? pos_i : '0;
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign nv       = (AccumW'(elem_i.accum) << 3) + (AccumW'(elem_i.accum) << 1)
                  + AccumW'(byte_i - ChZero);
  assign left_dec = (left_i != '0) ? left_i - LeftW'(1) : left_i;
  assign rem_dec  = (elem_i.remaining != '0) ? elem_i.remaining - BulkW'(1)
                                             : elem_i.remaining;

  always_comb begin
    if (elem_i.kind == KIND_INT) begin
      limit = elem_i.neg ? IntNegLimit : IntPosLimit;
    end else if (elem_i.kind == KIND_BULK) begin
      limit = AccumW'(max_bulk_i);
    end else begin
      limit = ArrayLimit;
    end
  end

  always_comb begin
    elem_o      = elem_i;
    left_o      = left_i;
    pos_o       = pos_i;
    inside_o    = inside_i;
    res_valid_o = 1'b0;
    res_o       = ResNone;
    do_num      = 1'b0;
    do_fail     = 1'b0;
    fail_kind   = elem_i.kind;
    fail_code   = ERR_NONE;
    do_fin      = 1'b0;
    fin_val     = '0;

    unique case (elem_i.phase)
      PH_IDLE: begin
        elem_o = ElemClear;
        if (byte_i == ChStar) begin
          if (inside_i) begin
            do_fail   = 1'b1;
            fail_kind = KIND_ARRAY;
            fail_code = ERR_NESTED;
          end else begin
            elem_o.kind  = KIND_ARRAY;
            elem_o.phase = PH_NUM;
          end
        end else if (byte_i == ChColon || byte_i == ChPlus || byte_i == ChMinus ||
                     byte_i == ChDollar) begin
          if (byte_i == ChColon) begin
            elem_o.kind  = KIND_INT;
            elem_o.phase = PH_SIGN;
          end else if (byte_i == ChPlus) begin
            elem_o.kind  = KIND_SIMPLE;
            elem_o.phase = PH_SIMPLE;
          end else if (byte_i == ChMinus) begin
            elem_o.kind  = KIND_ERR;
            elem_o.phase = PH_SIMPLE;
          end else begin
            elem_o.kind  = KIND_BULK;
            elem_o.phase = PH_NUM;
          end
          res_valid_o      = 1'b1;
          res_o.event_res  = EV_START;
          res_o.elem_type  = elem_o.kind;
          res_o.elem_index = idx;
        end else begin
          do_fail   = 1'b1;
          fail_kind = KIND_INT;
          fail_code = ERR_BAD_TYPE;
        end
      end

      PH_SIGN: begin
        elem_o.phase = PH_NUM;
        if (byte_i == ChMinus) begin
          elem_o.neg = 1'b1;
        end else if (byte_i != ChPlus) begin
          do_num = 1'b1;
        end
      end

      PH_NUM: begin
        do_num = 1'b1;
      end

      PH_NUM_LF: begin
        if (byte_i != ChLf) begin
          do_fail   = 1'b1;
          fail_code = ERR_MISSING_LF;
        end else if (elem_i.kind == KIND_INT) begin
          do_fin  = 1'b1;
          fin_val = elem_i.neg ? ValueW'(0) - elem_i.accum : elem_i.accum;
        end else if (elem_i.kind == KIND_BULK) begin
          elem_o.remaining = elem_i.accum[BulkW-1:0];
          elem_o.phase     = (elem_i.accum == '0) ? PH_BULK_CR : PH_BULK;
        end else begin
          elem_o          = ElemClear;
          res_valid_o     = 1'b1;
          res_o.event_res = EV_ARRAY_HDR;
          res_o.elem_type = KIND_ARRAY;
          if (elem_i.accum == '0) begin
            res_o.msg_last = 1'b1;
          end else begin
            inside_o    = 1'b1;
            left_o      = LeftW'(elem_i.accum);
            pos_o       = '0;
            res_o.value = elem_i.accum;
          end
        end
      end

      PH_SIMPLE: begin
        if (byte_i == ChCr) begin
          elem_o.phase = PH_SIMPLE_LF;
        end else if (byte_i == ChLf) begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_TERM;
        end else if (elem_i.simple_cnt >= max_simple_i) begin
          do_fail   = 1'b1;
          fail_code = ERR_TOO_LONG;
        end else begin
          elem_o.simple_cnt = elem_i.simple_cnt + SimpleW'(1);
          res_valid_o       = 1'b1;
          res_o.event_res   = EV_PAYLOAD;
          res_o.elem_type   = elem_i.kind;
          res_o.data_byte   = byte_i;
          res_o.elem_index  = idx;
        end
      end

      PH_SIMPLE_LF: begin
        if (byte_i != ChLf) begin
          do_fail   = 1'b1;
          fail_code = ERR_MISSING_LF;
        end else begin
          do_fin  = 1'b1;
          fin_val = ValueW'(elem_i.simple_cnt);
        end
      end

      PH_BULK: begin
        elem_o.remaining = rem_dec;
        if (rem_dec == '0) begin
          elem_o.phase = PH_BULK_CR;
        end
        res_valid_o      = 1'b1;
        res_o.event_res  = EV_PAYLOAD;
        res_o.elem_type  = KIND_BULK;
        res_o.data_byte  = byte_i;
        res_o.elem_index = idx;
      end

      PH_BULK_CR: begin
        if (byte_i != ChCr) begin
          do_fail   = 1'b1;
          fail_kind = KIND_BULK;
          fail_code = ERR_BAD_TERM;
        end else begin
          elem_o.phase = PH_BULK_LF;
        end
      end

      PH_BULK_LF: begin
        if (byte_i != ChLf) begin
          do_fail   = 1'b1;
          fail_kind = KIND_BULK;
          fail_code = ERR_MISSING_LF;
        end else begin
          do_fin  = 1'b1;
          fin_val = elem_i.accum;
        end
      end

      default: begin
        elem_o = ElemClear;
      end
    endcase

    // Decimal header digits, shared by integers, bulk lengths and array counts.
    if (do_num) begin
      if (is_digit) begin
        if (nv > limit) begin
          do_fail   = 1'b1;
          fail_code = (elem_i.kind == KIND_INT) ? ERR_OVERFLOW : ERR_TOO_LONG;
        end else begin
          elem_o.accum      = nv[ValueW-1:0];
          elem_o.digit_seen = 1'b1;
        end
      end else if (byte_i == ChCr && elem_i.digit_seen) begin
        elem_o.phase = PH_NUM_LF;
      end else begin
        do_fail   = 1'b1;
        fail_code = ERR_BAD_DIGIT;
      end
    end

    if (do_fin) begin
      elem_o           = ElemClear;
      res_valid_o      = 1'b1;
      res_o.event_res  = EV_END;
      res_o.elem_type  = elem_i.kind;
      res_o.value      = fin_val;
      res_o.elem_index = idx;
      res_o.msg_last   = 1'b1;
      if (inside_i) begin
        left_o = left_dec;
        pos_o  = pos_i + IndexW'(1);
        if (left_dec == '0) begin
          inside_o = 1'b0;
          pos_o    = '0;
        end else begin
          res_o.msg_last = 1'b0;
        end
      end
    end

    if (do_fail) begin
      elem_o           = ElemClear;
      left_o           = '0;
      pos_o            = '0;
      inside_o         = 1'b0;
      res_valid_o      = 1'b1;
      res_o            = ResNone;
      res_o.event_res  = EV_ERROR;
      res_o.elem_type  = fail_kind;
      res_o.elem_index = pos_i;
      res_o.error_code = fail_code;
    end
  end

endmodule

`default_nettype wire
